// File: rtl/core/i2c_rm_pkg.sv
package i2c_rm_pkg;

    localparam int PhaseWidth  = 16;
    localparam int SettleWidth = 24;
    localparam logic [PhaseWidth-1:0]  PhaseReset  = 16'd2;
    localparam logic [SettleWidth-1:0] SettleReset = 24'd10000;
    localparam int QueueDepth = 2;
    localparam logic [7:0] MsbMask = 8'h80;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [0:0] {
        CFG_PHASE  = 1'b0,
        CFG_SETTLE = 1'b1
    } cfg_index_t;

    // Classified request handed from the front part to the sequencer.
    typedef struct packed {
        logic       is_tick;
        logic       is_write;
        logic       is_read;
        logic [7:0] slave_addr;
        logic [7:0] reg_addr;
        logic [7:0] write_data;
        logic [7:0] read_count;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       last_byte;
        logic       nack_seen;
    } res_t;

endpackage

// File: rtl/core/i2c_rm_front.sv
module i2c_rm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic [7:0]         slave_addr,
    input  logic [7:0]         reg_addr,
    input  logic [7:0]         write_data,
    input  logic [7:0]         read_count,
    input  logic               sda_in,
    output logic               cmd_valid,
    output i2c_rm_pkg::cmd_t   cmd,
    input  logic               cmd_take
);
    import i2c_rm_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    cmd_t            mem_reg [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]   cnt_reg, cnt_next;
    cmd_t            in_cmd;
    logic            do_push;
    logic            do_pop;

    always_comb
    begin
        in_cmd = '0;
        in_cmd.is_tick    = (action_t'(action) == ACT_TICK);
        in_cmd.is_write   = (action_t'(action) == ACT_WRITE);
        in_cmd.is_read    = (action_t'(action) == ACT_READ);
        in_cmd.slave_addr = slave_addr;
        in_cmd.reg_addr   = reg_addr;
        in_cmd.write_data = write_data;
        in_cmd.read_count = read_count;
        in_cmd.sda_in     = sda_in;
    end

    assign full      = (cnt_reg == (PtrW+1)'(QueueDepth));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// File: rtl/core/i2c_rm_seq.sv
module i2c_rm_seq #(
    parameter int PhaseW  = i2c_rm_pkg::PhaseWidth,
    parameter int SettleW = i2c_rm_pkg::SettleWidth
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [PhaseW-1:0]   phase_ticks,
    input  logic [SettleW-1:0]  settle_ticks,
    input  logic                cmd_valid,
    input  i2c_rm_pkg::cmd_t    cmd,
    output logic                cmd_take,
    output logic                res_valid,
    output i2c_rm_pkg::res_t    res,
    input  logic                res_take
);
    import i2c_rm_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE      = 15'b000000000000001,
        S_START_HI  = 15'b000000000000010,
        S_START_LO  = 15'b000000000000100,
        S_TX_SETUP  = 15'b000000000001000,
        S_TX_HIGH   = 15'b000000000010000,
        S_TX_HOLD   = 15'b000000000100000,
        S_ACK_HIGH  = 15'b000000001000000,
        S_ACK_LOW   = 15'b000000010000000,
        S_RX_LOW    = 15'b000000100000000,
        S_RX_HIGH   = 15'b000001000000000,
        S_MACK_LOW  = 15'b000010000000000,
        S_MACK_HIGH = 15'b000100000000000,
        S_STOP_LO   = 15'b001000000000000,
        S_STOP_HI   = 15'b010000000000000,
        S_SETTLE    = 15'b100000000000000
    } state_t;

    state_t             st_reg, st_next;
    logic [PhaseW-1:0]  phase_reg, phase_next;
    logic [SettleW-1:0] settle_reg, settle_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         left_reg, left_next;
    logic [7:0]         slave_reg, slave_next;
    logic [7:0]         regad_reg, regad_next;
    logic [7:0]         data_reg, data_next;
    logic               nack_reg, nack_next;
    logic [2:0]         stage_reg, stage_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               drv_reg, drv_next;
    logic               out_v_reg;
    res_t               out_reg, out_next;
    logic               got;
    logic [PhaseW-1:0]  limit;
    logic [PhaseW-1:0]  phase_inc;
    logic [3:0]         bit_inc;
    logic               advance;

    // A new item is taken whenever the single output register is free or drained now.
    assign advance   = cmd_valid && (!out_v_reg || res_take);
    assign cmd_take  = advance;
    assign res_valid = out_v_reg;
    assign res       = out_reg;
    assign limit     = (phase_ticks == '0) ? PhaseW'(1) : phase_ticks;
    assign phase_inc = phase_reg + 1'b1;
    assign bit_inc   = bit_reg + 1'b1;

    always_comb
    begin
        st_next     = st_reg;
        phase_next  = phase_reg;
        settle_next = settle_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        left_next   = left_reg;
        slave_next  = slave_reg;
        regad_next  = regad_reg;
        data_next   = data_reg;
        nack_next   = nack_reg;
        stage_next  = stage_reg;
        got         = 1'b0;

        if (cmd.is_write || cmd.is_read)
        begin
            if (st_reg == S_IDLE)
            begin
                slave_next = cmd.slave_addr;
                regad_next = cmd.reg_addr;
                data_next  = cmd.write_data;
                left_next  = cmd.is_read ? cmd.read_count : 8'd0;
                nack_next  = 1'b0;
                stage_next = cmd.is_read ? 3'd3 : 3'd0;
                st_next    = S_START_HI;
                phase_next = '0;
                bit_next   = '0;
            end
        end
        else if (cmd.is_tick && st_reg != S_IDLE)
        begin
            if (st_reg == S_SETTLE)
            begin
                settle_next = settle_reg - 1'b1;
                if (settle_next == '0)
                begin
                    st_next = S_IDLE;
                end
            end
            else if (phase_inc < limit)
            begin
                phase_next = phase_inc;
            end
            else
            begin
                phase_next = '0;
                unique case (st_reg)
                    S_START_HI:
                    begin
                        if (bit_reg == '0)
                        begin
                            bit_next = 4'd1;
                        end
                        else
                        begin
                            st_next  = S_START_LO;
                            bit_next = '0;
                        end
                    end
                    S_START_LO:
                    begin
                        if (bit_reg == '0)
                        begin
                            bit_next = 4'd1;
                        end
                        else
                        begin
                            st_next  = S_TX_SETUP;
                            bit_next = '0;
                            shift_next = (stage_reg == 3'd1 || stage_reg == 3'd4) ? regad_reg
                                       : (stage_reg == 3'd2) ? data_reg
                                       : (stage_reg == 3'd5) ? slave_reg + 8'd1
                                       : slave_reg;
                        end
                    end
                    S_TX_SETUP: st_next = S_TX_HIGH;
                    S_TX_HIGH:  st_next = S_TX_HOLD;
                    S_TX_HOLD:
                    begin
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_inc;
                        st_next    = (bit_inc >= 4'd8) ? S_ACK_HIGH : S_TX_SETUP;
                    end
                    S_ACK_HIGH:
                    begin
                        if (cmd.sda_in)
                        begin
                            nack_next = 1'b1;
                        end
                        st_next = S_ACK_LOW;
                    end
                    S_ACK_LOW:
                    begin
                        if (stage_reg == 3'd0 || stage_reg == 3'd1 || stage_reg == 3'd3)
                        begin
                            stage_next = stage_reg + 3'd1;
                            bit_next   = '0;
                            st_next    = S_TX_SETUP;
                            shift_next = (stage_reg == 3'd0) ? regad_reg
                                       : (stage_reg == 3'd1) ? data_reg
                                       : regad_reg;
                        end
                        else if (stage_reg == 3'd4)
                        begin
                            stage_next = 3'd5;
                            bit_next   = '0;
                            st_next    = S_START_HI;
                        end
                        else if (stage_reg == 3'd5 && left_reg != '0)
                        begin
                            shift_next = '0;
                            bit_next   = '0;
                            st_next    = S_RX_LOW;
                        end
                        else
                        begin
                            bit_next = '0;
                            st_next  = S_STOP_LO;
                        end
                    end
                    S_RX_LOW: st_next = S_RX_HIGH;
                    S_RX_HIGH:
                    begin
                        shift_next = {shift_reg[6:0], cmd.sda_in};
                        bit_next   = bit_inc;
                        if (bit_inc >= 4'd8)
                        begin
                            st_next = S_MACK_LOW;
                            got     = 1'b1;
                        end
                        else
                        begin
                            st_next = S_RX_LOW;
                        end
                    end
                    S_MACK_LOW: st_next = S_MACK_HIGH;
                    S_MACK_HIGH:
                    begin
                        left_next = left_reg - 8'd1;
                        if (left_next == '0)
                        begin
                            bit_next = '0;
                            st_next  = S_STOP_LO;
                        end
                        else
                        begin
                            shift_next = '0;
                            bit_next   = '0;
                            st_next    = S_RX_LOW;
                        end
                    end
                    S_STOP_LO:
                    begin
                        if (bit_reg == '0)
                        begin
                            bit_next = 4'd1;
                        end
                        else
                        begin
                            bit_next = '0;
                            st_next  = S_STOP_HI;
                        end
                    end
                    S_STOP_HI:
                    begin
                        if (bit_reg == '0)
                        begin
                            bit_next = 4'd1;
                        end
                        else if (stage_reg == 3'd2 && settle_ticks != '0)
                        begin
                            bit_next    = '0;
                            st_next     = S_SETTLE;
                            settle_next = settle_ticks;
                        end
                        else
                        begin
                            bit_next = '0;
                            st_next  = S_IDLE;
                        end
                    end
                    default: st_next = S_IDLE;
                endcase
            end
        end
    end

    // Pin levels follow the state entered.
    always_comb
    begin
        scl_next = scl_reg;
        sda_next = sda_reg;
        drv_next = drv_reg;
        if (st_next != st_reg || st_next == S_TX_SETUP || st_next == S_RX_LOW)
        begin
            unique case (st_next)
                S_START_LO:  {scl_next, sda_next, drv_next} = 3'b101;
                S_TX_SETUP, S_TX_HOLD:
                    {scl_next, sda_next, drv_next} = {1'b0, shift_next[7], 1'b1};
                S_TX_HIGH:   {scl_next, sda_next, drv_next} = {1'b1, shift_next[7], 1'b1};
                S_ACK_HIGH, S_RX_HIGH: {scl_next, sda_next, drv_next} = 3'b110;
                S_ACK_LOW, S_RX_LOW:   {scl_next, sda_next, drv_next} = 3'b010;
                S_MACK_LOW:  {scl_next, sda_next, drv_next} = {1'b0, left_next == 8'd1, 1'b1};
                S_MACK_HIGH: {scl_next, sda_next, drv_next} = {1'b1, left_next == 8'd1, 1'b1};
                S_STOP_LO:   {scl_next, sda_next, drv_next} = 3'b001;
                default:     {scl_next, sda_next, drv_next} = 3'b111;
            endcase
        end
        out_next = '0;
        out_next.scl        = scl_next;
        out_next.sda_out    = sda_next;
        out_next.sda_drive  = drv_next;
        out_next.busy_res   = (st_next != S_IDLE);
        out_next.read_valid = got;
        out_next.read_byte  = got ? shift_next : 8'd0;
        out_next.last_byte  = got && (left_next == 8'd1);
        out_next.nack_seen  = nack_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            phase_reg  <= '0;
            settle_reg <= '0;
            bit_reg    <= '0;
            shift_reg  <= '0;
            left_reg   <= '0;
            slave_reg  <= '0;
            regad_reg  <= '0;
            data_reg   <= '0;
            nack_reg   <= 1'b0;
            stage_reg  <= '0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            drv_reg    <= 1'b1;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                st_reg     <= st_next;
                phase_reg  <= phase_next;
                settle_reg <= settle_next;
                bit_reg    <= bit_next;
                shift_reg  <= shift_next;
                left_reg   <= left_next;
                slave_reg  <= slave_next;
                regad_reg  <= regad_next;
                data_reg   <= data_next;
                nack_reg   <= nack_next;
                stage_reg  <= stage_next;
                scl_reg    <= scl_next;
                sda_reg    <= sda_next;
                drv_reg    <= drv_next;
                out_v_reg  <= 1'b1;
            end
            else if (res_take)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/core/i2c_register_master.sv
// I2C register master, stepped by tick requests.
// Input channel: push/full. Each request carries action (tick, start write,
// start read or none), the transaction fields and the sampled data line level.
// Output channel: empty/pop. Every accepted request yields exactly one result
// holding the driven clock and data levels, the busy flag, any byte that was
// completed on that tick and the sticky missing-acknowledge flag.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// index 0 sets the ticks per bus phase, index 1 the busy time after a
// write's stop. Writes are always taken and must come while the block is idle.
// A request passes a two-entry queue and then the sequencer, which writes its result
// into a single output register and handles one request per cycle while that register
// is free or being popped; a pushed request is stored in the queue first and its
// result is registered when the sequencer takes it.
// When the receiver stops popping, the output register holds its result, the
// queue fills and full rises; nothing is lost.
// Reset returns to idle with both lines driven high and registers at their
// defaults (two ticks per phase, ten thousand settle ticks).
module i2c_register_master #(
    parameter int PhaseW  = i2c_rm_pkg::PhaseWidth,
    parameter int SettleW = i2c_rm_pkg::SettleWidth
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         action,
    input  logic [7:0]         slave_addr,
    input  logic [7:0]         reg_addr,
    input  logic [7:0]         write_data,
    input  logic [7:0]         read_count,
    input  logic               sda_in,
    output logic               empty,
    input  logic               pop,
    output logic               scl,
    output logic               sda_out,
    output logic               sda_drive,
    output logic               busy_res,
    output logic               read_valid,
    output logic [7:0]         read_byte,
    output logic               last_byte,
    output logic               nack_seen,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [SettleW-1:0] cfg_data
);
    import i2c_rm_pkg::*;

    logic [PhaseW-1:0]  phase_ticks_reg;
    logic [SettleW-1:0] settle_ticks_reg;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_take;
    logic               res_valid;
    res_t               res;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg  <= PhaseW'(PhaseReset);
            settle_ticks_reg <= SettleW'(SettleReset);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PHASE:  phase_ticks_reg  <= cfg_data[PhaseW-1:0];
                CFG_SETTLE: settle_ticks_reg <= cfg_data;
                default:    phase_ticks_reg  <= phase_ticks_reg;
            endcase
        end
    end

    i2c_rm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .action     (action),
        .slave_addr (slave_addr),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .read_count (read_count),
        .sda_in     (sda_in),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_take   (cmd_take)
    );

    i2c_rm_seq #(
        .PhaseW  (PhaseW),
        .SettleW (SettleW)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .phase_ticks  (phase_ticks_reg),
        .settle_ticks (settle_ticks_reg),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .res_valid    (res_valid),
        .res          (res),
        .res_take     (pop)
    );

    assign empty      = !res_valid;
    assign scl        = res.scl;
    assign sda_out    = res.sda_out;
    assign sda_drive  = res.sda_drive;
    assign busy_res   = res.busy_res;
    assign read_valid = res.read_valid;
    assign read_byte  = res.read_byte;
    assign last_byte  = res.last_byte;
    assign nack_seen  = res.nack_seen;

endmodule

// File: test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_rm_pkg::*;

    // The predictor walks the same bus states as the block, one name per step of the
    // waveform.
    typedef enum logic [3:0] {
        S_IDLE, S_START_HI, S_START_LO, S_TX_SETUP, S_TX_HIGH, S_TX_HOLD,
        S_ACK_HIGH, S_ACK_LOW, S_RX_LOW, S_RX_HIGH, S_MACK_LOW, S_MACK_HIGH,
        S_STOP_LO, S_STOP_HI, S_SETTLE
    } bus_state_t;

    // Which byte of the transaction is on the wire.
    typedef enum logic [2:0] {
        BYTE_W_SLAVE, BYTE_W_REG, BYTE_W_DATA,
        BYTE_R_SLAVE, BYTE_R_REG, BYTE_R_SLAVE_RD
    } byte_stage_t;

    typedef struct {
        action_t    act;
        logic [7:0] slave;
        logic [7:0] regad;
        logic [7:0] data;
        logic [7:0] count;
        logic       sda;
    } bus_req_t;

    localparam int IdlePct    = 24;
    localparam int StallLen   = 400;
    localparam int QuietLimit = 5000;
    localparam int TailCycles = 8;
    localparam int ItemsGoal  = 800;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic [1:0] action = ACT_TICK;
    logic [7:0] slave_addr = '0;
    logic [7:0] reg_addr = '0;
    logic [7:0] write_data = '0;
    logic [7:0] read_count = '0;
    logic sda_in = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic scl, sda_out, sda_drive, busy_res, read_valid, last_byte, nack_seen;
    logic [7:0] read_byte;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_index = CFG_PHASE;
    logic [SettleWidth-1:0] cfg_data = '0;

    always #4 clk = ~clk;

    i2c_register_master DUT (.*);

    // Requests waiting to be offered and results the predictor has worked out.
    bus_req_t pending_reqs[$];
    res_t     bus_levels_due[$];

    int  errors = 0;
    int  items_sent = 0;
    bit  no_idle = 1'b0;
    int  stall_token = 0;

    // Copy of the block's registers and sequencer state.
    logic [15:0] m_phase_ticks;
    logic [23:0] m_settle_ticks;
    bus_state_t  m_state;
    byte_stage_t m_stage;
    logic [15:0] m_phase;
    logic [23:0] m_settle;
    logic [3:0]  m_bits;
    logic [7:0]  m_shift, m_left, m_slave, m_reg, m_data;
    logic        m_nack, m_scl, m_sda, m_drive;

    function automatic void set_lines(logic c, logic d, logic drv);
        m_scl = c;
        m_sda = d;
        m_drive = drv;
    endfunction

    function automatic void move_to(bus_state_t s);
        logic tx;
        logic ack_level;
        tx = m_shift[7];
        // The master acknowledges every byte but the last, which gets a high level.
        ack_level = (m_left == 8'd1);
        m_state = s;
        m_phase = '0;
        case (s)
            S_START_HI:  begin m_bits = '0; set_lines(1, 1, 1); end
            S_START_LO:  begin m_bits = '0; set_lines(1, 0, 1); end
            S_TX_SETUP:  set_lines(0, tx, 1);
            S_TX_HIGH:   set_lines(1, tx, 1);
            S_TX_HOLD:   set_lines(0, tx, 1);
            S_ACK_HIGH:  set_lines(1, 1, 0);
            S_ACK_LOW:   set_lines(0, 1, 0);
            S_RX_LOW:    set_lines(0, 1, 0);
            S_RX_HIGH:   set_lines(1, 1, 0);
            S_MACK_LOW:  set_lines(0, ack_level, 1);
            S_MACK_HIGH: set_lines(1, ack_level, 1);
            S_STOP_LO:   begin m_bits = '0; set_lines(0, 0, 1); end
            S_STOP_HI:   begin m_bits = '0; set_lines(1, 1, 1); end
            default:     set_lines(1, 1, 1);
        endcase
    endfunction

    function automatic void load_byte();
        case (m_stage)
            BYTE_W_SLAVE, BYTE_R_SLAVE: m_shift = m_slave;
            BYTE_W_REG, BYTE_R_REG:     m_shift = m_reg;
            BYTE_W_DATA:                m_shift = m_data;
            default:                    m_shift = m_slave + 8'd1;
        endcase
        m_bits = '0;
        move_to(S_TX_SETUP);
    endfunction

    function automatic void start_rx_byte();
        m_shift = '0;
        m_bits = '0;
        move_to(S_RX_LOW);
    endfunction

    // Handles the last tick of a phase; returns 1 when a received byte is complete.
    function automatic bit end_of_phase(logic sda);
        case (m_state)
            S_START_HI, S_START_LO, S_STOP_LO:
                if (m_bits == 0) begin
                    m_bits = 1;
                    m_phase = '0;
                end else if (m_state == S_START_HI) move_to(S_START_LO);
                else if (m_state == S_START_LO) load_byte();
                else move_to(S_STOP_HI);
            S_TX_SETUP: move_to(S_TX_HIGH);
            S_TX_HIGH:  move_to(S_TX_HOLD);
            S_TX_HOLD:
            begin
                m_shift = m_shift << 1;
                m_bits = m_bits + 1;
                move_to(m_bits >= 8 ? S_ACK_HIGH : S_TX_SETUP);
            end
            S_ACK_HIGH:
            begin
                if (sda) m_nack = 1'b1;
                move_to(S_ACK_LOW);
            end
            S_ACK_LOW:
                if (m_stage inside {BYTE_W_SLAVE, BYTE_W_REG, BYTE_R_SLAVE}) begin
                    m_stage = byte_stage_t'(m_stage + 1);
                    load_byte();
                end else if (m_stage == BYTE_R_REG) begin
                    // Repeated start before the read address.
                    m_stage = BYTE_R_SLAVE_RD;
                    move_to(S_START_HI);
                end else if (m_stage == BYTE_R_SLAVE_RD && m_left != 0) start_rx_byte();
                else move_to(S_STOP_LO);
            S_RX_LOW: move_to(S_RX_HIGH);
            S_RX_HIGH:
            begin
                m_shift = {m_shift[6:0], sda};
                m_bits = m_bits + 1;
                if (m_bits >= 8) begin
                    move_to(S_MACK_LOW);
                    return 1'b1;
                end
                move_to(S_RX_LOW);
            end
            S_MACK_LOW: move_to(S_MACK_HIGH);
            S_MACK_HIGH:
            begin
                m_left = m_left - 1;
                if (m_left == 0) move_to(S_STOP_LO);
                else start_rx_byte();
            end
            S_STOP_HI:
                if (m_bits == 0) begin
                    m_bits = 1;
                    m_phase = '0;
                end else if (m_stage == BYTE_W_DATA && m_settle_ticks != 0) begin
                    move_to(S_SETTLE);
                    m_settle = m_settle_ticks;
                end else move_to(S_IDLE);
            default: move_to(S_IDLE);
        endcase
        return 1'b0;
    endfunction

    function automatic void reset_model();
        m_phase_ticks = PhaseReset;
        m_settle_ticks = SettleReset;
        m_state = S_IDLE;
        m_stage = BYTE_W_SLAVE;
        m_phase = '0;
        m_settle = '0;
        m_bits = '0;
        {m_shift, m_left, m_slave, m_reg, m_data} = '0;
        m_nack = 1'b0;
        set_lines(1, 1, 1);
    endfunction

    function automatic res_t predict_levels(bus_req_t r);
        res_t o;
        bit got;
        logic [15:0] lim;
        got = 1'b0;
        lim = (m_phase_ticks == 0) ? 16'd1 : m_phase_ticks;
        if (r.act inside {ACT_WRITE, ACT_READ}) begin
            // A start request while a transaction runs is dropped.
            if (m_state == S_IDLE) begin
                m_slave = r.slave;
                m_reg = r.regad;
                m_data = r.data;
                m_left = (r.act == ACT_READ) ? r.count : 8'd0;
                m_nack = 1'b0;
                m_stage = (r.act == ACT_READ) ? BYTE_R_SLAVE : BYTE_W_SLAVE;
                move_to(S_START_HI);
            end
        end else if (r.act == ACT_TICK && m_state != S_IDLE) begin
            if (m_state == S_SETTLE) begin
                m_settle = m_settle - 1;
                if (m_settle == 0) move_to(S_IDLE);
            end else begin
                m_phase = m_phase + 1;
                if (m_phase >= lim) got = end_of_phase(r.sda);
            end
        end
        o.scl = m_scl;
        o.sda_out = m_sda;
        o.sda_drive = m_drive;
        o.busy_res = (m_state != S_IDLE);
        o.read_valid = got;
        o.read_byte = got ? m_shift : 8'd0;
        o.last_byte = got && (m_left == 8'd1);
        o.nack_seen = m_nack;
        return o;
    endfunction

    // Driver: offers the oldest pending request and runs the predictor on acceptance.
    always @(posedge clk) begin
        bit take;
        take = push && !full;
        if (take) begin
            bus_levels_due.push_back(predict_levels(pending_reqs[0]));
            void'(pending_reqs.pop_front());
        end
        if (pending_reqs.size() == 0) begin
            push <= 1'b0;
        end else if (take || !push) begin
            if (no_idle || $urandom_range(99) >= IdlePct) begin
                push <= 1'b1;
                action <= pending_reqs[0].act;
                slave_addr <= pending_reqs[0].slave;
                reg_addr <= pending_reqs[0].regad;
                write_data <= pending_reqs[0].data;
                read_count <= pending_reqs[0].count;
                sda_in <= pending_reqs[0].sda;
            end else begin
                push <= 1'b0;
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Monitor: compares every popped result with the oldest prediction and keeps the
    // watchdog that ends a run where nothing moves for too long.
    int stall_left = 0;
    int stall_seen = 0;
    int quiet = 0;

    always @(posedge clk) begin
        res_t want;
        if (pop && !empty) begin
            if (bus_levels_due.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
            end else begin
                want = bus_levels_due.pop_front();
                check_field("scl", want.scl, scl);
                check_field("sda_out", want.sda_out, sda_out);
                check_field("sda_drive", want.sda_drive, sda_drive);
                check_field("busy_res", want.busy_res, busy_res);
                check_field("read_valid", want.read_valid, read_valid);
                check_field("read_byte", want.read_byte, read_byte);
                check_field("last_byte", want.last_byte, last_byte);
                check_field("nack_seen", want.nack_seen, nack_seen);
            end
        end
        if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= QuietLimit) begin
            $display("%0t: watchdog expired", $time);
            $display("*** FAILED ***");
            $finish;
        end
        // A new stall token from the stimulus starts a long hold-off on the output side.
        if (stall_token != stall_seen) begin
            stall_seen <= stall_token;
            stall_left <= StallLen;
            pop <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            pop <= 1'b0;
        end else begin
            pop <= no_idle || ($urandom_range(99) >= IdlePct);
        end
    end

    task automatic add_req(action_t act, logic [7:0] sa, logic [7:0] ra,
                           logic [7:0] wd, logic [7:0] rc);
        bus_req_t r;
        r.act = act;
        r.slave = sa;
        r.regad = ra;
        r.data = wd;
        r.count = rc;
        r.sda = $urandom_range(1);
        pending_reqs.push_back(r);
        if (act != ACT_NONE) items_sent++;
    endtask

    task automatic add_tick();
        add_req(ACT_TICK, $urandom_range(255), $urandom_range(255),
                $urandom_range(255), $urandom_range(255));
    endtask

    task automatic wait_sent();
        while (pending_reqs.size() != 0) @(posedge clk);
    endtask

    // Ticks in small bursts until the predictor says the transaction is over, now
    // and then slipping in a start request or an unused code, which the block ignores while a transaction runs.
    task automatic tick_until_idle(int noise_pct);
        do begin
            repeat ($urandom_range(1, 16)) add_tick();
            if ($urandom_range(99) < noise_pct)
                add_req(action_t'($urandom_range(ACT_WRITE, ACT_NONE)), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255));
            wait_sent();
        end while (m_state != S_IDLE);
    endtask

    task automatic transact(action_t act, logic [7:0] sa, logic [7:0] ra,
                            logic [7:0] wd, logic [7:0] rc);
        add_req(act, sa, ra, wd, rc);
        tick_until_idle(3);
    endtask

    // Waits until every request has been answered and the pipeline is quiet.
    task automatic drain();
        while (pending_reqs.size() != 0 || push || bus_levels_due.size() != 0)
            @(posedge clk);
        repeat (TailCycles) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [23:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        cfg_valid <= 1'b0;
        if (idx == CFG_PHASE) m_phase_ticks = value[15:0];
        else m_settle_ticks = value;
    endtask

    initial begin
        int pick;
        reset_model();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset phase time: a full write with a short settle wait.
        write_reg(CFG_SETTLE, 24'd8);
        transact(ACT_WRITE, 8'hFF, 8'h00, 8'hA5, 8'h00);
        add_req(ACT_NONE, 8'h12, 8'h34, 8'h56, 8'h78);
        drain();

        // Zero phase time behaves as one tick; no settle time ends a write at stop.
        write_reg(CFG_PHASE, 24'd0);
        write_reg(CFG_SETTLE, 24'd0);
        transact(ACT_WRITE, 8'h00, 8'hFF, 8'hFF, 8'h00);
        // Read address wraps from all ones to zero; the single byte is also the last.
        transact(ACT_READ, 8'hFF, 8'h80, 8'h00, 8'h01);
        drain();

        // Largest register values, only ticked while the bus is idle.
        write_reg(CFG_PHASE, 24'hFFFF);
        write_reg(CFG_SETTLE, 24'hFFFFFF);
        repeat (6) add_tick();
        drain();

        // Random part, in several settings of the two registers.
        for (int ph = 0; items_sent < ItemsGoal; ph++) begin
            write_reg(CFG_PHASE, $urandom_range(1));
            write_reg(CFG_SETTLE, ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 16));
            no_idle = (ph == 1);
            if (ph == 0) stall_token++;
            for (int t = 0; t < 2; t++) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    // Stray ticks and unused codes with no transaction behind them.
                    repeat ($urandom_range(1, 6)) add_tick();
                    add_req(ACT_NONE, $urandom_range(255), $urandom_range(255),
                            $urandom_range(255), $urandom_range(255));
                end else if (pick < 50) begin
                    transact(ACT_WRITE, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), $urandom_range(255));
                end else begin
                    transact(ACT_READ, $urandom_range(255), $urandom_range(255),
                             $urandom_range(255), $urandom_range(4));
                end
            end
            no_idle = 1'b0;
            drain();
        end

        drain();
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
